>>> hw/rtl/slt_pkg.sv
// Shared types and constants for the small language tokenizer.
package slt_pkg;

   // Width of the position and length counters; they saturate at all ones.
   localparam int POS_BITS = 16;

   // Largest value an integer token can carry.
   localparam logic [30:0] VAL_MAX = 31'h7FFF_FFFF;

   // Token kinds as they appear on the result channel.
   typedef enum logic [4:0] {
      KIND_LET    = 5'd0,
      KIND_PRINT  = 5'd1,
      KIND_IF     = 5'd2,
      KIND_ELSE   = 5'd3,
      KIND_WHILE  = 5'd4,
      KIND_IDENT  = 5'd5,
      KIND_INT    = 5'd6,
      KIND_ASSIGN = 5'd7,
      KIND_PLUS   = 5'd8,
      KIND_MINUS  = 5'd9,
      KIND_MUL    = 5'd10,
      KIND_DIV    = 5'd11,
      KIND_EQ     = 5'd12,
      KIND_NE     = 5'd13,
      KIND_LT     = 5'd14,
      KIND_GT     = 5'd15,
      KIND_LE     = 5'd16,
      KIND_GE     = 5'd17,
      KIND_SEMI   = 5'd18,
      KIND_LBRACE = 5'd19,
      KIND_RBRACE = 5'd20,
      KIND_END    = 5'd21,
      KIND_ERROR  = 5'd22
   } tok_kind_type;

   // One input word: a source byte or the end marker.
   typedef struct packed {
      logic [7:0] char_byte;
      logic       end_of_text;
   } req_type;

   // One result word: a token.
   typedef struct packed {
      tok_kind_type token_kind;
      logic [15:0]  start_pos;
      logic [15:0]  token_len;
      logic [30:0]  int_value;
      logic         value_overflow;
      logic         last_of_run;
   } rsp_type;

endpackage

>>> hw/rtl/small_language_tokenizer.sv
// Streaming tokenizer: source bytes in, tokens out.
//
//   Channel   Direction  Handshake            Word
//   req_      in         req_valid/req_ready  req_type (char_byte, end_of_text)
//   rsp_      out        rsp_valid/rsp_ready  rsp_type (one token)
//
// One input word is taken per cycle; the scanner decides all its tokens in the
// cycle it takes the word and writes them into a three-entry result queue.
// The result port drains one token per cycle while rsp_ready is high; input is
// taken whenever the queue holds one token or fewer. Reset is synchronous
// and empties the queue and the scanner.
// A stalled result port fills the queue and then holds off input.
module small_language_tokenizer (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  slt_pkg::req_type req_word,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output slt_pkg::rsp_type rsp_word
);
   import slt_pkg::*;

   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_NUM,
      MODE_IDENT,
      MODE_EQ,
      MODE_LT,
      MODE_GT,
      MODE_BANG,
      MODE_ERR
   } mode_type;

   localparam logic [POS_BITS-1:0] POS_ONE = POS_BITS'(1);

   // Increment that sticks at all ones.
   function automatic logic [POS_BITS-1:0] sat_inc(logic [POS_BITS-1:0] v);
      return (&v) ? v : v + POS_ONE;
   endfunction

   // Clip a position or length to the 16-bit result field.
   function automatic logic [15:0] clip_pos(logic [POS_BITS-1:0] v);
      logic [POS_BITS+16:0] w;
      w = (POS_BITS+17)'(v);
      if (w > (POS_BITS+17)'(17'h0FFFF)) begin
         return 16'hFFFF;
      end
      return w[15:0];
   endfunction

   // Scanner state.
   mode_type            mode_ff, mode_in;
   logic [POS_BITS-1:0] pos_ff, pos_in;
   logic [POS_BITS-1:0] tstart_ff, tstart_in;
   logic [POS_BITS-1:0] tlen_ff, tlen_in;
   logic [30:0]         acc_ff, acc_in;
   logic [39:0]         kw_ff, kw_in;
   logic                ovf_ff, ovf_in;

   // Result queue; entry 0 is the head.
   rsp_type             q_ff [3];
   rsp_type             q_in [3];
   logic [1:0]          cnt_ff, cnt_in;

   logic                req_take;
   logic                pop;
   logic [1:0]          base;
   logic [7:0]          c;
   logic                is_space, is_digit, is_alpha, is_word;
   logic [34:0]         prod;

   rsp_type             pend_tok, pair_tok, start_tok, end_tok, tok_a, tok_b;
   rsp_type             res0, res1;
   logic                pend_valid, start_emit, emit_a, emit_b, push0, push1;
   mode_type            start_mode;
   tok_kind_type        kw_kind;

   assign req_ready = (cnt_ff <= 2'd1);
   assign req_take  = req_valid & req_ready;
   assign rsp_valid = (cnt_ff != 2'd0);
   assign rsp_word  = q_ff[0];
   assign pop       = rsp_valid & rsp_ready;

   // Character classes.
   always_comb begin
      c        = req_word.char_byte;
      is_space = (c == 8'd32) || (c inside {[8'd9:8'd13]});
      is_digit = c inside {["0":"9"]};
      is_alpha = (c inside {["a":"z"]}) || (c inside {["A":"Z"]});
      is_word  = is_alpha || is_digit || (c == "_");
      prod     = (35'(acc_ff) << 3) + (35'(acc_ff) << 1) + 35'(c[3:0]);
   end

   // Keyword match on the first five bytes of an identifier.
   always_comb begin
      kw_kind = KIND_IDENT;
      if (tlen_ff == POS_BITS'(3) && kw_ff == 40'h00_006C_6574) begin
         kw_kind = KIND_LET;
      end else if (tlen_ff == POS_BITS'(5) && kw_ff == 40'h70_7269_6E74) begin
         kw_kind = KIND_PRINT;
      end else if (tlen_ff == POS_BITS'(2) && kw_ff == 40'h00_0000_6966) begin
         kw_kind = KIND_IF;
      end else if (tlen_ff == POS_BITS'(4) && kw_ff == 40'h00_656C_7365) begin
         kw_kind = KIND_ELSE;
      end else if (tlen_ff == POS_BITS'(5) && kw_ff == 40'h77_6869_6C65) begin
         kw_kind = KIND_WHILE;
      end
   end

   // Token still pending in the scanner, flushed when something ends it.
   always_comb begin
      pend_valid              = mode_ff inside {MODE_NUM, MODE_IDENT, MODE_EQ,
                                                MODE_LT, MODE_GT, MODE_BANG};
      pend_tok                = '0;
      pend_tok.start_pos      = clip_pos(tstart_ff);
      pend_tok.token_len      = 16'd1;
      pend_tok.token_kind     = KIND_ERROR;
      case (mode_ff)
         MODE_NUM: begin
            pend_tok.token_kind     = KIND_INT;
            pend_tok.token_len      = clip_pos(tlen_ff);
            pend_tok.int_value      = acc_ff;
            pend_tok.value_overflow = ovf_ff;
         end
         MODE_IDENT: begin
            pend_tok.token_kind = kw_kind;
            pend_tok.token_len  = clip_pos(tlen_ff);
         end
         MODE_EQ:   pend_tok.token_kind = KIND_ASSIGN;
         MODE_LT:   pend_tok.token_kind = KIND_LT;
         MODE_GT:   pend_tok.token_kind = KIND_GT;
         default:   pend_tok.token_kind = KIND_ERROR;
      endcase

      // Two-character comparison completed by an equals sign.
      pair_tok           = '0;
      pair_tok.start_pos = clip_pos(tstart_ff);
      pair_tok.token_len = 16'd2;
      case (mode_ff)
         MODE_EQ:  pair_tok.token_kind = KIND_EQ;
         MODE_LT:  pair_tok.token_kind = KIND_LE;
         MODE_GT:  pair_tok.token_kind = KIND_GE;
         default:  pair_tok.token_kind = KIND_NE;
      endcase

      end_tok            = '0;
      end_tok.token_kind = KIND_END;
      end_tok.start_pos  = clip_pos(pos_ff);
   end

   // What the current byte does when it starts a new token.
   always_comb begin
      start_tok            = '0;
      start_tok.start_pos  = clip_pos(pos_ff);
      start_tok.token_len  = 16'd1;
      start_tok.token_kind = KIND_ERROR;
      start_emit           = 1'b0;
      start_mode           = MODE_IDLE;
      if (is_space) begin
         start_mode = MODE_IDLE;
      end else if (is_digit) begin
         start_mode = MODE_NUM;
      end else if (is_alpha || c == "_") begin
         start_mode = MODE_IDENT;
      end else begin
         case (c)
            "=": start_mode = MODE_EQ;
            "<": start_mode = MODE_LT;
            ">": start_mode = MODE_GT;
            "!": start_mode = MODE_BANG;
            "+": begin start_emit = 1'b1; start_tok.token_kind = KIND_PLUS;   end
            "-": begin start_emit = 1'b1; start_tok.token_kind = KIND_MINUS;  end
            "*": begin start_emit = 1'b1; start_tok.token_kind = KIND_MUL;    end
            "/": begin start_emit = 1'b1; start_tok.token_kind = KIND_DIV;    end
            ";": begin start_emit = 1'b1; start_tok.token_kind = KIND_SEMI;   end
            "{": begin start_emit = 1'b1; start_tok.token_kind = KIND_LBRACE; end
            "}": begin start_emit = 1'b1; start_tok.token_kind = KIND_RBRACE; end
            default: begin
               start_emit = 1'b1;
               start_mode = MODE_ERR;
            end
         endcase
      end
   end

   // Scanner step for one accepted word.
   always_comb begin
      mode_in   = mode_ff;
      pos_in    = pos_ff;
      tstart_in = tstart_ff;
      tlen_in   = tlen_ff;
      acc_in    = acc_ff;
      kw_in     = kw_ff;
      ovf_in    = ovf_ff;
      emit_a    = 1'b0;
      emit_b    = 1'b0;
      tok_a     = pend_tok;
      tok_b     = start_tok;

      if (req_take) begin
         if (req_word.end_of_text) begin
            // Flush, report the end, and restart at offset zero.
            emit_a    = pend_valid;
            emit_b    = 1'b1;
            tok_b     = end_tok;
            mode_in   = MODE_IDLE;
            pos_in    = '0;
            tstart_in = '0;
            tlen_in   = '0;
            acc_in    = '0;
            kw_in     = '0;
            ovf_in    = 1'b0;
         end else begin
            pos_in = sat_inc(pos_ff);
            if (mode_ff == MODE_ERR) begin
               // Discard until the end marker.
               mode_in = MODE_ERR;
            end else if (mode_ff == MODE_NUM && is_digit) begin
               if (prod > 35'(VAL_MAX)) begin
                  acc_in = VAL_MAX;
                  ovf_in = 1'b1;
               end else begin
                  acc_in = prod[30:0];
               end
               tlen_in = sat_inc(tlen_ff);
            end else if (mode_ff == MODE_IDENT && is_word) begin
               if (tlen_ff < POS_BITS'(5)) begin
                  kw_in = {kw_ff[31:0], c};
               end
               tlen_in = sat_inc(tlen_ff);
            end else if ((mode_ff inside {MODE_EQ, MODE_LT, MODE_GT, MODE_BANG})
                         && c == "=") begin
               emit_a  = 1'b1;
               tok_a   = pair_tok;
               mode_in = MODE_IDLE;
            end else if (mode_ff == MODE_BANG) begin
               // A lone bang is an error; the bytes after it are dropped up to the end marker.
               emit_a  = 1'b1;
               mode_in = MODE_ERR;
            end else begin
               // End any pending token, then let this byte start a new one.
               emit_a    = pend_valid;
               emit_b    = start_emit;
               mode_in   = start_mode;
               tstart_in = pos_ff;
               tlen_in   = POS_ONE;
               acc_in    = is_digit ? 31'(c[3:0]) : '0;
               kw_in     = {32'd0, c};
               ovf_in    = 1'b0;
            end
         end
      end
   end

   // Pack the tokens of this word into queue slots in order.
   always_comb begin
      push0             = emit_a | emit_b;
      push1             = emit_a & emit_b;
      res0              = emit_a ? tok_a : tok_b;
      res0.last_of_run  = ~push1;
      res1              = tok_b;
      res1.last_of_run  = 1'b1;
   end

   // Result queue: shift on pop, write new tokens behind what remains.
   always_comb begin
      base    = cnt_ff - 2'(pop);
      q_in[0] = pop ? q_ff[1] : q_ff[0];
      q_in[1] = pop ? q_ff[2] : q_ff[1];
      q_in[2] = q_ff[2];
      for (int i = 0; i < 3; i++) begin
         if (push0 && base == 2'(i)) begin
            q_in[i] = res0;
         end
         if (push1 && (base + 2'd1) == 2'(i)) begin
            q_in[i] = res1;
         end
      end
      cnt_in = base + 2'(push0) + 2'(push1);
   end

   // All registers.
   always_ff @(posedge clock) begin
      tstart_ff <= tstart_in;
      tlen_ff   <= tlen_in;
      acc_ff    <= acc_in;
      kw_ff     <= kw_in;
      ovf_ff    <= ovf_in;
      q_ff      <= q_in;
      if (reset) begin
         mode_ff <= MODE_IDLE;
         pos_ff  <= '0;
         cnt_ff  <= '0;
      end else begin
         mode_ff <= mode_in;
         pos_ff  <= pos_in;
         cnt_ff  <= cnt_in;
      end
   end

endmodule

>>> hw/rtl/slt_checker.sv
// Port checker for the small language tokenizer, bound to the top level.
module slt_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input slt_pkg::req_type req_word,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input slt_pkg::rsp_type rsp_word
);
   import slt_pkg::*;

   // A token waiting on a stalled port stays put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
      else $error("result word changed while stalled");

   // Reset leaves no token on the port.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // The end token has no length and always closes its run.
   a_end_token: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.token_kind == KIND_END |->
         rsp_word.token_len == 16'd0 && rsp_word.last_of_run)
      else $error("malformed end token");

   // Only integer tokens carry a value.
   a_value_int: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.token_kind != KIND_INT |->
         rsp_word.int_value == '0 && !rsp_word.value_overflow)
      else $error("value on a non-integer token");

   // An overflowed integer is saturated.
   a_overflow_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.value_overflow |-> rsp_word.int_value == VAL_MAX)
      else $error("overflow flag without saturated value");

endmodule

bind small_language_tokenizer slt_checker u_slt_checker (.*);
